FILE: sv/sha_pkg.sv
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } sha_item_t;

    localparam int FifoDepth = 2;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;
    localparam logic [5:0] LastPos = 6'd63;

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] r;
        begin
            case (i)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                default: r = 32'h5be0cd19;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] r;
        begin
            case (i)
                6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
                6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
                6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
                6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
                6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
                6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
                6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
                6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
                6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
                6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
                6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
                6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
                6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
                6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
                6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
                6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
                6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
                6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
                6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
                6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
                6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
                6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
                6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
                6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
                6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
                6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
                6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
                6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
                6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
                6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
                6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
                6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/sha256_stream_hasher_core.sv
// SHA-256 stream hasher.
// Input channel (push/full): one item per transfer; command 0 absorbs
// data_byte, command 1 pads the message and produces its digest.
// Output channel (empty/pop): eight transfers per finish, digest_word in
// order H0..H7 with word_index 0..7 and last_word on the eighth.
// A two-entry input queue decouples the producer from the hash engine.
// A data byte is shifted into the block; each 64th byte also starts the
// rounds and then the add step on the single round unit.
// A finish feeds the pad, zero fill and length one byte per cycle, paused
// while a full block is compressed (an extra block is added when needed),
// then holds the digest for the reader.
// While the reader stalls the digest stays on the ports and the engine
// takes no new item; queued input items wait.
// Reset loads the standard initial hash value and clears the byte count.
`default_nettype none
module sha256_stream_hasher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic [7:0]  data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    logic               item_valid;
    logic               item_take;
    sha_pkg::sha_item_t item;

    sha_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .command    (command),
        .data_byte  (data_byte),
        .full       (full),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    sha_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .empty       (empty),
        .pop         (pop)
    );

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_end_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && last_word) |=> empty)
        else $error("results continue after last digest word");

    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> (word_index == 3'd0))
        else $error("digest does not start at word 0");

endmodule
`default_nettype wire

FILE: sv/sha_front.sv
`default_nettype none
module sha_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               command,
    input  wire logic [7:0]         data_byte,
    output logic                    full,
    output logic                    item_valid,
    output sha_pkg::sha_item_t      item,
    input  wire logic               item_take
);

    sha_pkg::sha_item_t fifo_reg [sha_pkg::FifoDepth];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'(sha_pkg::FifoDepth));
    assign item_valid = (count_reg != 2'd0);
    assign item       = fifo_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // classify on entry: finish command vs data byte
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[wr_ptr_reg].finish <= command;
            fifo_reg[wr_ptr_reg].data   <= command ? 8'h00 : data_byte;
        end
    end

endmodule
`default_nettype wire

FILE: sv/sha_back.sv
`default_nettype none
module sha_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  sha_pkg::sha_item_t      item,
    output logic                    item_take,
    output logic [31:0]             digest_word,
    output logic [2:0]              word_index,
    output logic                    last_word,
    output logic                    empty,
    input  wire logic               pop
);

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_ADD, S_EMIT} state_t;
    typedef enum logic [1:0] {PH_MARK, PH_ZERO, PH_LEN} phase_t;

    state_t      state_reg, state_next;
    phase_t      ph_reg, ph_next;
    logic        final_reg, final_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] total_reg, total_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic [511:0] blk_reg, blk_next;
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];

    logic [7:0]  in_byte;
    logic        ins;
    logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
    logic [31:0] big1, big0, ch, maj, t1;
    logic [2:0]  lsel;

    assign w0  = blk_reg[511 -: 32];
    assign w1  = blk_reg[479 -: 32];
    assign w9  = blk_reg[223 -: 32];
    assign w14 = blk_reg[63 -: 32];
    assign s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
    assign s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
    assign w_new = w0 + s0 + w9 + s1;

    assign big1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
                ^ {v_reg[4][24:0], v_reg[4][31:25]};
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + sha_pkg::round_k(rnd_reg) + w0;
    assign big0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
                ^ {v_reg[0][21:0], v_reg[0][31:22]};
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);

    assign lsel = ~fill_reg[2:0];

    assign item_take   = (state_reg == S_IDLE) && item_valid;
    assign empty       = (state_reg != S_EMIT);
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        final_next = final_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        blk_next   = blk_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        in_byte    = item.data;
        ins        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.finish)
                    begin
                        bits_next  = {total_reg, 3'b000};
                        ph_next    = PH_MARK;
                        state_next = S_PAD;
                    end
                    else
                    begin
                        ins        = 1'b1;
                        total_next = total_reg + 61'd1;
                    end
                end
            end
            S_PAD:
            begin
                ins = 1'b1;
                case (ph_reg)
                    PH_MARK: in_byte = sha_pkg::PadByte;
                    PH_LEN:  in_byte = bits_reg[8 * lsel +: 8];
                    default: in_byte = 8'h00;
                endcase
                if (ph_reg != PH_LEN && fill_reg + 6'd1 == sha_pkg::LenPos)
                    ph_next = PH_LEN;
                else if (ph_reg == PH_MARK)
                    ph_next = PH_ZERO;
                if (ph_reg == PH_LEN && fill_reg == sha_pkg::LastPos)
                    final_next = 1'b1;
            end
            S_ROUND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + big0 + maj;
                blk_next  = {blk_reg[479:0], w_new};
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    h_next[i] = h_reg[i] + v_reg[i];
                if (final_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = S_EMIT;
                end
                else if (ph_reg != PH_MARK || bits_reg != 64'd0 && 1'b0)
                    state_next = S_PAD;
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (pop)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                            h_next[i] = sha_pkg::init_h(3'(i));
                        total_next = 61'd0;
                        final_next = 1'b0;
                        ph_next    = PH_MARK;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        // shift one byte into the block; a full block starts the rounds
        if (ins)
        begin
            blk_next  = {blk_reg[503:0], in_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == sha_pkg::LastPos)
            begin
                v_next     = h_reg;
                rnd_next   = 6'd0;
                state_next = S_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_MARK;
            final_reg <= 1'b0;
            fill_reg  <= 6'd0;
            total_reg <= 61'd0;
            rnd_reg   <= 6'd0;
            idx_reg   <= 3'd0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha_pkg::init_h(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            final_reg <= final_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        blk_reg  <= blk_next;
        v_reg    <= v_next;
    end

endmodule
`default_nettype wire

FILE: verif/sha256_stream_hasher_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module sha256_stream_hasher_core_test;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_out_t;

    localparam logic FinishCmd = 1'b1;
    localparam logic AbsorbCmd = 1'b0;
    localparam int   CycleLimit = 2000000;

    class digest_scoreboard;
        logic [31:0] hash_state [8];
        logic [7:0]  block_bytes [64];
        int unsigned fill;
        logic [60:0] total_bytes;
        digest_out_t pending_words [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            hash_state[0] = 32'h6a09e667; hash_state[1] = 32'hbb67ae85;
            hash_state[2] = 32'h3c6ef372; hash_state[3] = 32'ha54ff53a;
            hash_state[4] = 32'h510e527f; hash_state[5] = 32'h9b05688c;
            hash_state[6] = 32'h1f83d9ab; hash_state[7] = 32'h5be0cd19;
            fill = 0;
            total_bytes = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function logic [31:0] round_const(int i);
            logic [31:0] k [64];
            k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                  32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                  32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                  32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                  32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                  32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                  32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                  32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                  32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                  32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                  32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                  32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                  32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                  32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                  32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                  32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            return k[i];
        endfunction

        function void compress_block();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            v = hash_state;
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(i) + w[i];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hash_state[i] += v[i];
        endfunction

        function void note_item(logic cmd, logic [7:0] data);
            logic [63:0] bit_len;
            digest_out_t d;
            if (cmd == AbsorbCmd)
            begin
                block_bytes[fill] = data;
                fill++;
                total_bytes++;
                if (fill == 64)
                begin
                    compress_block();
                    fill = 0;
                end
                return;
            end
            bit_len = {total_bytes, 3'b000};
            block_bytes[fill] = 8'h80;
            fill++;
            if (fill > 56)
            begin
                for (int i = fill; i < 64; i++)
                    block_bytes[i] = 8'h00;
                compress_block();
                fill = 0;
            end
            for (int i = fill; i < 56; i++)
                block_bytes[i] = 8'h00;
            for (int i = 0; i < 8; i++)
                block_bytes[63-i] = bit_len[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash_state[i];
                d.word_index  = 3'(i);
                d.last_word   = (i == 7);
                pending_words.push_back(d);
            end
            restart();
        endfunction

        function void check_word(digest_out_t got);
            digest_out_t exp_w;
            if (pending_words.size() == 0)
            begin
                $error("unexpected digest word %h", got.digest_word);
                errors++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (got.digest_word !== exp_w.digest_word)
            begin
                $error("digest_word: expected %h, got %h", exp_w.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== exp_w.word_index)
            begin
                $error("word_index: expected %0d, got %0d", exp_w.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== exp_w.last_word)
            begin
                $error("last_word: expected %0b, got %0b", exp_w.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        command;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_scoreboard board;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count;

    sha256_stream_hasher_core u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(command), .data_byte(data_byte), .empty(empty),
        .pop(pop), .digest_word(digest_word), .word_index(word_index),
        .last_word(last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // note every transfer on both sides at the edge
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            board.note_item(command, data_byte);
        if (rst_n && pop && !empty)
            board.check_word(digest_out_t'{digest_word, word_index, last_word});
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("sha256_stream_hasher_core_test: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // hold the item until transferred; optionally idle before the next one
    task automatic send_item(logic cmd, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        command   <= cmd;
        data_byte <= data;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_message(int len, int mode);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: send_item(AbsorbCmd, 8'($urandom));
                1: send_item(AbsorbCmd, 8'h00);
                2: send_item(AbsorbCmd, 8'hff);
                default: send_item(AbsorbCmd, 8'(i));
            endcase
        end
        send_item(FinishCmd, 8'($urandom));
    endtask

    task automatic random_phase(int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(9))
                0: len = 0;
                1: len = 55 + $urandom_range(10);
                2: len = 119 + $urandom_range(10);
                default: len = $urandom_range(20);
            endcase
            send_message(len, 0);
            sent += len + 1;
        end
    endtask

    initial
    begin
        board         = new();
        cycle_count   = 0;
        rst_n         = 1'b0;
        push          = 1'b0;
        command       = AbsorbCmd;
        data_byte     = 8'h00;
        send_idle_pct = 25;
        recv_idle_pct = 87;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, then all-one and all-zero bytes, counting messages of 1 and 56 bytes
        send_message(0, 0);
        send_message(3, 2);
        send_message(2, 1);
        send_message(1, 3);
        send_message(56, 3);
        random_phase(80);

        send_idle_pct = 87;
        recv_idle_pct = 25;
        random_phase(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(80);
        push <= 1'b0;

        while (board.pending_words.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.errors == 0)
            $display("sha256_stream_hasher_core_test: clean");
        else
            $display("sha256_stream_hasher_core_test: errors");
        $finish;
    end

endmodule
`default_nettype wire
